@@ rtl/hpr_pkg.sv @@
package hpr_pkg;

    // request kinds on the input channel
    localparam logic REQ_PIX_WRITE = 1'b0;
    localparam logic REQ_TICK      = 1'b1;

    // configuration register indexes
    localparam logic CFG_PASS_COUNT = 1'b0;
    localparam logic CFG_ON_TICKS   = 1'b1;

    localparam logic [2:0]  PASS_COUNT_RESET = 3'd7;
    localparam logic [15:0] ON_TICKS_RESET   = 16'd50;

    localparam int PIX_W      = 8;
    localparam int SCAN_ROW_W = 4;
    localparam int COL_CNT_W  = 7;
    localparam int PASS_W     = 3;
    localparam int TIMER_W    = 16;

    typedef enum logic [1:0] {
        PH_SHIFT = 2'b01,
        PH_SHOW  = 2'b10
    } phase_t;

    typedef logic [PIX_W-1:0] pix_t;

    // frame buffer read request from the scan side
    typedef struct packed {
        logic en;
        logic hold;
    } fb_rd_ctl_t;

endpackage

@@ rtl/hub75_panel_refresh_core.sv @@
// Dual-scan HUB75 refresh engine with an RGB332 frame buffer held in a two-read,
// one-write RAM. Pixel writes and refresh ticks share the request channel and
// can be taken back to back; a tick's pin states appear in the output register in
// the cycle after it is taken. Pixel writes are taken even while a result is
// held by out_stall; ticks wait for the output register to free up. After reset
// the frame buffer is swept to zero, one entry per cycle, over all
// 2**(clog2(PANEL_HEIGHT)+clog2(PANEL_WIDTH)) entries (2048 at the defaults);
// in_stall stays high during the sweep, configuration writes are still taken.
module hub75_panel_refresh_core #(
    parameter int PANEL_WIDTH  = 64,
    parameter int PANEL_HEIGHT = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [4:0]  pix_row,
    input  logic [5:0]  pix_col,
    input  logic [7:0]  pix_color,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        red_top,
    output logic        green_top,
    output logic        blue_top,
    output logic        red_bottom,
    output logic        green_bottom,
    output logic        blue_bottom,
    output logic [3:0]  row_addr,
    output logic        shift_clk,
    output logic        latch,
    output logic        output_enable_n,
    output logic        frame_done
);

    localparam int COL_W     = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;
    localparam int ROW_W     = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int HALF_ROWS = PANEL_HEIGHT / 2;

    logic [2:0]  pass_count_reg;
    logic [15:0] on_ticks_reg;

    hpr_pkg::phase_t                      phase_reg, phase_next;
    logic [hpr_pkg::COL_CNT_W-1:0]        column_count_reg, column_count_next;
    logic [hpr_pkg::SCAN_ROW_W-1:0]       scan_row_reg, scan_row_next;
    logic [hpr_pkg::PASS_W-1:0]           pass_index_reg, pass_index_next;
    logic [hpr_pkg::TIMER_W-1:0]          on_timer_reg, on_timer_next;
    logic                                 frame_done_next;

    logic                                 out_valid_reg;
    logic                                 out_shift_reg;
    logic [hpr_pkg::SCAN_ROW_W-1:0]       out_row_reg;
    logic [hpr_pkg::PASS_W-1:0]           out_thr_reg;
    logic                                 out_frame_done_reg;

    logic        clearing;
    logic        is_tick;
    logic        accept;
    logic        tick_go;
    logic        out_free;
    logic        pix_in_range;
    logic [6:0]  col_inc;
    logic [4:0]  row_inc;
    logic [3:0]  pass_inc;
    logic [15:0] timer_inc;
    logic [15:0] limit;
    logic [2:0]  passes;
    logic [4:0]  top_row;
    logic [4:0]  bot_row;

    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr_a;
    logic [ADDR_W-1:0]   rd_addr_b;
    hpr_pkg::pix_t       pix_top;
    hpr_pkg::pix_t       pix_bot;
    hpr_pkg::fb_rd_ctl_t rd_ctl;

    // ---------------- request handshake ----------------
    assign is_tick  = (req_type == hpr_pkg::REQ_TICK);
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = clearing || (is_tick && !out_free);
    assign accept   = in_valid && !in_stall;
    assign tick_go  = accept && is_tick;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_count_reg <= hpr_pkg::PASS_COUNT_RESET;
            on_ticks_reg   <= hpr_pkg::ON_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hpr_pkg::CFG_PASS_COUNT: pass_count_reg <= cfg_data[2:0];
                hpr_pkg::CFG_ON_TICKS:   on_ticks_reg   <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // ---------------- frame buffer ----------------
    assign pix_in_range = ({1'b0, pix_row} < 6'(PANEL_HEIGHT))
                       && ({1'b0, pix_col} < 7'(PANEL_WIDTH));
    assign wr_addr = {pix_row[ROW_W-1:0], pix_col[COL_W-1:0]};

    assign top_row   = {1'b0, scan_row_reg};
    assign bot_row   = top_row + 5'(HALF_ROWS);
    assign rd_addr_a = {top_row[ROW_W-1:0], column_count_reg[COL_W-1:0]};
    assign rd_addr_b = {bot_row[ROW_W-1:0], column_count_reg[COL_W-1:0]};

    assign rd_ctl.en   = tick_go && (phase_reg == hpr_pkg::PH_SHIFT);
    assign rd_ctl.hold = 1'b0;

    hpr_fbuf #(
        .ADDR_W (ADDR_W)
    ) u_fbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (accept && !is_tick && pix_in_range),
        .wr_addr   (wr_addr),
        .wr_data   (pix_color),
        .rd_ctl    (rd_ctl),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (pix_top),
        .rd_data_b (pix_bot),
        .clearing  (clearing)
    );

    // ---------------- scan sequencer ----------------
    assign col_inc   = column_count_reg + 7'd1;
    assign row_inc   = {1'b0, scan_row_reg} + 5'd1;
    assign pass_inc  = {1'b0, pass_index_reg} + 4'd1;
    assign timer_inc = on_timer_reg + 16'd1;
    assign limit     = (on_ticks_reg != '0) ? on_ticks_reg : 16'd1;
    assign passes    = (pass_count_reg != '0) ? pass_count_reg : 3'd1;

    always_comb
    begin
        phase_next        = phase_reg;
        column_count_next = column_count_reg;
        scan_row_next     = scan_row_reg;
        pass_index_next   = pass_index_reg;
        on_timer_next     = on_timer_reg;
        frame_done_next   = 1'b0;
        case (phase_reg)
            hpr_pkg::PH_SHIFT:
            begin
                column_count_next = col_inc;
                if (col_inc >= 7'(PANEL_WIDTH))
                begin
                    phase_next    = hpr_pkg::PH_SHOW;
                    on_timer_next = '0;
                end
            end
            hpr_pkg::PH_SHOW:
            begin
                on_timer_next = timer_inc;
                // timer wrap also ends the row
                if (timer_inc >= limit || timer_inc == '0)
                begin
                    phase_next        = hpr_pkg::PH_SHIFT;
                    column_count_next = '0;
                    on_timer_next     = '0;
                    scan_row_next     = row_inc[3:0];
                    if (row_inc >= 5'(HALF_ROWS))
                    begin
                        scan_row_next   = '0;
                        pass_index_next = pass_inc[2:0];
                        if (pass_inc >= {1'b0, passes})
                        begin
                            pass_index_next = '0;
                            frame_done_next = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                phase_next = hpr_pkg::PH_SHIFT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= hpr_pkg::PH_SHIFT;
            column_count_reg <= '0;
            scan_row_reg     <= '0;
            pass_index_reg   <= '0;
            on_timer_reg     <= '0;
        end
        else if (tick_go)
        begin
            phase_reg        <= phase_next;
            column_count_reg <= column_count_next;
            scan_row_reg     <= scan_row_next;
            pass_index_reg   <= pass_index_next;
            on_timer_reg     <= on_timer_next;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= tick_go;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_go)
        begin
            out_shift_reg      <= (phase_reg == hpr_pkg::PH_SHIFT);
            out_row_reg        <= scan_row_reg;
            out_thr_reg        <= pass_index_reg;
            out_frame_done_reg <= frame_done_next;
        end
    end

    // pixel bytes are held in the RAM read registers until the next shift tick
    assign red_top      = out_shift_reg && (pix_top[7:5] > out_thr_reg);
    assign green_top    = out_shift_reg && (pix_top[4:2] > out_thr_reg);
    assign blue_top     = out_shift_reg && ({1'b0, pix_top[1:0]} > out_thr_reg);
    assign red_bottom   = out_shift_reg && (pix_bot[7:5] > out_thr_reg);
    assign green_bottom = out_shift_reg && (pix_bot[4:2] > out_thr_reg);
    assign blue_bottom  = out_shift_reg && ({1'b0, pix_bot[1:0]} > out_thr_reg);

    assign out_valid       = out_valid_reg;
    assign row_addr        = out_row_reg;
    assign shift_clk       = out_shift_reg;
    assign latch           = !out_shift_reg;
    assign output_enable_n = out_shift_reg;
    assign frame_done      = out_frame_done_reg;

endmodule

@@ rtl/hpr_fbuf.sv @@
module hpr_fbuf #(
    parameter int ADDR_W = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  hpr_pkg::pix_t       wr_data,
    input  hpr_pkg::fb_rd_ctl_t rd_ctl,
    input  logic [ADDR_W-1:0]   rd_addr_a,
    input  logic [ADDR_W-1:0]   rd_addr_b,
    output hpr_pkg::pix_t       rd_data_a,
    output hpr_pkg::pix_t       rd_data_b,
    output logic                clearing
);

    localparam int DEPTH = 2 ** ADDR_W;

    hpr_pkg::pix_t mem [DEPTH];

    logic              clr_active_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    hpr_pkg::pix_t     mem_wd;

    // sweep every entry to zero after reset, one per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        mem_we = clr_active_reg | wr_en;
        mem_wa = clr_active_reg ? clr_addr_reg : wr_addr;
        mem_wd = clr_active_reg ? '0 : wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_ctl.en && !rd_ctl.hold)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

    assign clearing = clr_active_reg;

endmodule

@@ verif/hub75_panel_refresh_core_checker.sv @@
module hub75_panel_refresh_core_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        req_type,
    input  logic [4:0]  pix_row,
    input  logic [5:0]  pix_col,
    input  logic [7:0]  pix_color,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        red_top,
    input  logic        green_top,
    input  logic        blue_top,
    input  logic        red_bottom,
    input  logic        green_bottom,
    input  logic        blue_bottom,
    input  logic [3:0]  row_addr,
    input  logic        shift_clk,
    input  logic        latch,
    input  logic        output_enable_n,
    input  logic        frame_done,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS      = 64;
    localparam int SCAN_ROWS = 16;
    localparam int FB_DEPTH  = 2048;

    typedef struct packed {
        logic       red_top;
        logic       green_top;
        logic       blue_top;
        logic       red_bottom;
        logic       green_bottom;
        logic       blue_bottom;
        logic [3:0] row_addr;
        logic       shift_clk;
        logic       latch;
        logic       oe_n;
        logic       frame_done;
    } panel_pins_t;

    hpr_pkg::pix_t pixel_mem [0:FB_DEPTH-1];
    logic [6:0]    col_cnt;
    logic [3:0]    scan_row;
    int            pass_idx;
    logic          showing;
    logic [15:0]   hold_timer;
    logic [2:0]    pass_count_r;
    logic [15:0]   on_ticks_r;

    panel_pins_t expected_pins [$];
    int          ticks_checked;

    initial
    begin
        fail_count    = 0;
        pending       = 0;
        ticks_checked = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_pin(input string name, input logic [3:0] got, input logic [3:0] want);
        if (got !== want)
            report_mismatch($sformatf("tick result %0d %s: got %0h expected %0h",
                                      ticks_checked, name, got, want));
    endtask

    // {r, g, b} lit when the channel value exceeds the pass threshold
    function automatic logic [2:0] lit_rgb(input hpr_pkg::pix_t px, input int thr);
        lit_rgb = {int'(px[7:5]) > thr, int'(px[4:2]) > thr, int'(px[1:0]) > thr};
    endfunction

    // pin states of one refresh tick; advances the scan state
    function automatic panel_pins_t next_pins();
        panel_pins_t p;
        int          hold_limit;
        int          passes;
        p = '0;
        p.row_addr = scan_row;
        if (!showing)
        begin
            {p.red_top, p.green_top, p.blue_top} =
                lit_rgb(pixel_mem[{1'b0, scan_row, col_cnt[5:0]}], pass_idx);
            {p.red_bottom, p.green_bottom, p.blue_bottom} =
                lit_rgb(pixel_mem[{1'b1, scan_row, col_cnt[5:0]}], pass_idx);
            p.shift_clk = 1'b1;
            p.oe_n      = 1'b1;
            col_cnt     = col_cnt + 7'd1;
            if (col_cnt >= COLS)
            begin
                showing    = 1'b1;
                hold_timer = '0;
            end
        end
        else
        begin
            p.latch    = 1'b1;
            hold_limit = (on_ticks_r == 0) ? 1 : int'(on_ticks_r);
            hold_timer = hold_timer + 16'd1;
            // timer may already be past a freshly lowered on_ticks
            if (int'(hold_timer) >= hold_limit || hold_timer == 0)
            begin
                showing    = 1'b0;
                col_cnt    = '0;
                hold_timer = '0;
                if (scan_row == SCAN_ROWS - 1)
                begin
                    scan_row = '0;
                    passes   = (pass_count_r == 0) ? 1 : int'(pass_count_r);
                    pass_idx++;
                    if (pass_idx >= passes)
                    begin
                        pass_idx     = 0;
                        p.frame_done = 1'b1;
                    end
                end
                else
                    scan_row = scan_row + 4'd1;
            end
        end
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        panel_pins_t seen;
        panel_pins_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < FB_DEPTH; i++)
                pixel_mem[i] = '0;
            col_cnt      = '0;
            scan_row     = '0;
            pass_idx     = 0;
            showing      = 1'b0;
            hold_timer   = '0;
            pass_count_r = hpr_pkg::PASS_COUNT_RESET;
            on_ticks_r   = hpr_pkg::ON_TICKS_RESET;
            expected_pins.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == hpr_pkg::CFG_PASS_COUNT)
                    pass_count_r = cfg_data[2:0];
                else
                    on_ticks_r = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                seen = {red_top, green_top, blue_top, red_bottom, green_bottom, blue_bottom,
                        row_addr, shift_clk, latch, output_enable_n, frame_done};
                if (expected_pins.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with no tick pending",
                                              ticks_checked));
                else
                begin
                    want = expected_pins.pop_front();
                    check_pin("red_top", seen.red_top, want.red_top);
                    check_pin("green_top", seen.green_top, want.green_top);
                    check_pin("blue_top", seen.blue_top, want.blue_top);
                    check_pin("red_bottom", seen.red_bottom, want.red_bottom);
                    check_pin("green_bottom", seen.green_bottom, want.green_bottom);
                    check_pin("blue_bottom", seen.blue_bottom, want.blue_bottom);
                    check_pin("row_addr", seen.row_addr, want.row_addr);
                    check_pin("shift_clk", seen.shift_clk, want.shift_clk);
                    check_pin("latch", seen.latch, want.latch);
                    check_pin("output_enable_n", seen.oe_n, want.oe_n);
                    check_pin("frame_done", seen.frame_done, want.frame_done);
                end
                ticks_checked++;
            end
            if (in_valid && !in_stall)
            begin
                if (req_type == hpr_pkg::REQ_TICK)
                    expected_pins.push_back(next_pins());
                else
                    pixel_mem[{pix_row, pix_col}] = pix_color;
            end
            pending = expected_pins.size();
        end
    end

endmodule

@@ verif/hub75_panel_refresh_core_tb.sv @@
module hub75_panel_refresh_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // long enough for the frame buffer clearing sweep after reset
    localparam int QUIET_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [4:0]  pix_row;
    logic [5:0]  pix_col;
    logic [7:0]  pix_color;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        red_top;
    logic        green_top;
    logic        blue_top;
    logic        red_bottom;
    logic        green_bottom;
    logic        blue_bottom;
    logic [3:0]  row_addr;
    logic        shift_clk;
    logic        latch;
    logic        output_enable_n;
    logic        frame_done;
    int          fail_count;
    int          pending;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          tick_total    = 0;
    int          quiet_cycles  = 0;

    hub75_panel_refresh_core u_dut (.*);

    hub75_panel_refresh_core_checker u_pin_check (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("hub75_panel_refresh_core test failed");
                $finish;
            end
        end
    end

    task automatic send_req(input logic kind, input logic [4:0] row, input logic [5:0] col,
                            input logic [7:0] color);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= kind;
        pix_row   <= row;
        pix_col   <= col;
        pix_color <= color;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // only with nothing in flight; a pixel write may still be settling
    task automatic cfg_write(input logic idx, input logic [15:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_ticks(input int n_ticks, input int write_pct);
        int sent;
        sent = 0;
        while (sent < n_ticks)
        begin
            if (tick_total < 530)
            begin
                send_idle_pct = 12;
                recv_idle_pct = 62;
            end
            else if (tick_total < 1060)
            begin
                send_idle_pct = 62;
                recv_idle_pct = 12;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(0, 99) < write_pct)
                send_req(hpr_pkg::REQ_PIX_WRITE, 5'($urandom_range(0, 31)),
                         6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
            else
            begin
                send_req(hpr_pkg::REQ_TICK, 5'($urandom), 6'($urandom), 8'($urandom));
                sent++;
                tick_total++;
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = hpr_pkg::CFG_PASS_COUNT;
        cfg_data  = '0;
        in_valid  = 1'b0;
        req_type  = hpr_pkg::REQ_PIX_WRITE;
        pix_row   = '0;
        pix_col   = '0;
        pix_color = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: corner pixels and single channels, then the first columns
        cfg_write(hpr_pkg::CFG_ON_TICKS, 16'd2);
        send_req(hpr_pkg::REQ_PIX_WRITE, 5'd0, 6'd0, 8'hFF);
        send_req(hpr_pkg::REQ_PIX_WRITE, 5'd16, 6'd0, 8'h00);
        send_req(hpr_pkg::REQ_PIX_WRITE, 5'd0, 6'd1, 8'hE0);
        send_req(hpr_pkg::REQ_PIX_WRITE, 5'd16, 6'd1, 8'h1C);
        send_req(hpr_pkg::REQ_PIX_WRITE, 5'd0, 6'd2, 8'h03);
        send_req(hpr_pkg::REQ_PIX_WRITE, 5'd16, 6'd2, 8'hFF);
        send_req(hpr_pkg::REQ_PIX_WRITE, 5'd31, 6'd63, 8'hFF);
        send_req(hpr_pkg::REQ_PIX_WRITE, 5'd15, 6'd63, 8'hA5);
        repeat (6) send_req(hpr_pkg::REQ_TICK, 5'd31, 6'd63, 8'hFF);

        // longest hold, then cut it short while the row is displayed
        cfg_write(hpr_pkg::CFG_PASS_COUNT, 16'h0007);
        cfg_write(hpr_pkg::CFG_ON_TICKS, 16'hFFFF);
        run_ticks(150, 8);
        cfg_write(hpr_pkg::CFG_ON_TICKS, 16'd3);
        // zero pass count acts as one, so this pass wraps the frame
        cfg_write(hpr_pkg::CFG_PASS_COUNT, 16'hFFF8);
        run_ticks(1020, 8);

        // zero hold acts as one tick
        cfg_write(hpr_pkg::CFG_PASS_COUNT, 16'd5);
        cfg_write(hpr_pkg::CFG_ON_TICKS, 16'd0);
        run_ticks(300, 8);

        cfg_write(hpr_pkg::CFG_ON_TICKS, 16'd1);
        run_ticks(120, 8);

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("hub75_panel_refresh_core test passed");
        else
            $display("hub75_panel_refresh_core test failed");
        $finish;
    end

endmodule
